// File: rtl/core/utf8_stream_decoder_core_macros.svh
// assertion macros shared by the utf8 stream decoder checks
// no dependencies; included by the checker file
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define USD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("usd check failed");

// property that must hold in the cycle after its trigger
`define USD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("usd check failed");

`endif

// File: rtl/core/usd_pkg.sv
// shared types and constants for the utf8 stream decoder
// no dependencies
package usd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CpWidth    = 21;
   localparam int unsigned LenWidth   = 3;
   localparam int unsigned NeedWidth  = 2;

   localparam logic [ByteWidth-1:0] NulByte     = 8'h00;
   localparam logic [ByteWidth-1:0] NewlineByte = 8'h0A;

   // sequence lengths
   localparam logic [LenWidth-1:0] LenEnd  = 3'd0;
   localparam logic [LenWidth-1:0] LenOne  = 3'd1;
   localparam logic [LenWidth-1:0] LenTwo  = 3'd2;
   localparam logic [LenWidth-1:0] LenThree = 3'd3;
   localparam logic [LenWidth-1:0] LenFour = 3'd4;

   // continuation bytes still expected
   localparam logic [NeedWidth-1:0] NeedNone  = 2'd0;
   localparam logic [NeedWidth-1:0] NeedOne   = 2'd1;
   localparam logic [NeedWidth-1:0] NeedTwo   = 2'd2;
   localparam logic [NeedWidth-1:0] NeedThree = 2'd3;

   typedef struct packed {
      logic [CpWidth-1:0]  code_point;
      logic [LenWidth-1:0] byte_length;
      logic                string_end;
   } usd_result_type;

endpackage

// File: rtl/core/usd_in_stage.sv
// input register of the utf8 stream decoder: holds one accepted byte
// depends on usd_pkg
module usd_in_stage
   import usd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteWidth-1:0] req_text_byte,
   input  logic                 advance,
   output logic                 held_valid,
   output logic [ByteWidth-1:0] held_byte
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [ByteWidth-1:0] byte_ff;
   logic [ByteWidth-1:0] byte_in;
   logic                 accept;

   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_text_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

// File: rtl/core/usd_decode.sv
// per-byte decode logic and open-sequence state
// depends on usd_pkg
module usd_decode
   import usd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ByteWidth-1:0] text_byte,
   input  logic                 step,
   output logic                 emit,
   output usd_result_type       result
);

   logic [NeedWidth-1:0] need_ff;
   logic [NeedWidth-1:0] need_in;
   logic [LenWidth-1:0]  len_ff;
   logic [LenWidth-1:0]  len_in;
   logic [CpWidth-1:0]   cp_ff;
   logic [CpWidth-1:0]   cp_in;
   logic                 is_cont;
   logic [CpWidth-1:0]   cp_shifted;

   assign is_cont    = (text_byte[7:6] == 2'b10);
   assign cp_shifted = {cp_ff[CpWidth-7:0], text_byte[5:0]};

   always_comb begin
      need_in            = need_ff;
      len_in             = len_ff;
      cp_in              = cp_ff;
      emit               = 1'b0;
      result.code_point  = '0;
      result.byte_length = LenEnd;
      result.string_end  = 1'b0;
      priority if (text_byte == NulByte || text_byte == NewlineByte) begin
         need_in           = NeedNone;
         emit              = 1'b1;
         result.string_end = 1'b1;
      end else if (need_ff != NeedNone && is_cont) begin
         cp_in   = cp_shifted;
         need_in = need_ff - NeedOne;
         if (need_ff == NeedOne) begin
            emit               = 1'b1;
            result.code_point  = cp_shifted;
            result.byte_length = len_ff;
         end
      end else begin
         // a broken sequence is dropped and the byte reread as a lead
         need_in = NeedNone;
         priority if (text_byte[7] == 1'b0) begin
            emit               = 1'b1;
            result.code_point  = {{(CpWidth-ByteWidth){1'b0}}, text_byte};
            result.byte_length = LenOne;
         end else if (text_byte[7:5] == 3'b110) begin
            need_in = NeedOne;
            len_in  = LenTwo;
            cp_in   = {{(CpWidth-5){1'b0}}, text_byte[4:0]};
         end else if (text_byte[7:4] == 4'b1110) begin
            need_in = NeedTwo;
            len_in  = LenThree;
            cp_in   = {{(CpWidth-4){1'b0}}, text_byte[3:0]};
         end else if (text_byte[7:3] == 5'b11110) begin
            need_in = NeedThree;
            len_in  = LenFour;
            cp_in   = {{(CpWidth-3){1'b0}}, text_byte[2:0]};
         end else begin
            // stray continuation or invalid lead: nothing to do
            need_in = NeedNone;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff <= NeedNone;
      end else if (step) begin
         need_ff <= need_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         len_ff <= len_in;
         cp_ff  <= cp_in;
      end
   end

endmodule

// File: rtl/core/usd_out_stage.sv
// result register of the utf8 stream decoder
// depends on usd_pkg
module usd_out_stage
   import usd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  usd_result_type      load_result,
   output logic                ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CpWidth-1:0]  rsp_code_point,
   output logic [LenWidth-1:0] rsp_byte_length,
   output logic                rsp_string_end
);

   logic           valid_ff;
   logic           valid_in;
   usd_result_type result_ff;
   usd_result_type result_in;

   assign ready = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = load_result;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = result_ff.code_point;
   assign rsp_byte_length = result_ff.byte_length;
   assign rsp_string_end  = result_ff.string_end;

endmodule

// File: rtl/core/utf8_stream_decoder_core.sv
// channel  direction  handshake          payload
// req      in         req_valid/stall    req_text_byte (8)
// rsp      out        rsp_valid/stall    rsp_code_point (21), rsp_byte_length (3), rsp_string_end
//
// one byte per cycle while req_stall is low; rsp is driven from the result register
// decode is shallow logic between the input register and the result register
// bytes that close no sequence leave the input register without waiting on rsp_stall
// reset is synchronous and closes any open sequence
// rsp_stall reaches req_stall only when the held byte has a result and rsp is full
module utf8_stream_decoder_core
   import usd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteWidth-1:0] req_text_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CpWidth-1:0]   rsp_code_point,
   output logic [LenWidth-1:0]  rsp_byte_length,
   output logic                 rsp_string_end
);

   logic                 held_valid;
   logic [ByteWidth-1:0] held_byte;
   logic                 emit;
   usd_result_type       result;
   logic                 out_ready;
   logic                 advance;

   // a byte moves on unless its result finds the result register full
   assign advance = held_valid & (~emit | out_ready);

   usd_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .advance       (advance),
      .held_valid    (held_valid),
      .held_byte     (held_byte)
   );

   usd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .text_byte (held_byte),
      .step      (advance),
      .emit      (emit),
      .result    (result)
   );

   usd_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .load            (advance & emit),
      .load_result     (result),
      .ready           (out_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_byte_length (rsp_byte_length),
      .rsp_string_end  (rsp_string_end)
   );

endmodule

// File: rtl/core/usd_checker.sv
// port-level checks on the utf8 stream decoder results
// depends on usd_pkg and utf8_stream_decoder_core_macros.svh
`include "utf8_stream_decoder_core_macros.svh"

module usd_checker
   import usd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [CpWidth-1:0]  rsp_code_point,
   input  logic [LenWidth-1:0] rsp_byte_length,
   input  logic                rsp_string_end
);

   // end of string carries no character
   `USD_ASSERT_SAME(a_end_empty, clock, reset, rsp_valid && rsp_string_end, rsp_code_point == '0 && rsp_byte_length == LenEnd)

   // a decoded character is one to four bytes long
   `USD_ASSERT_SAME(a_len_range, clock, reset, rsp_valid && !rsp_string_end, rsp_byte_length == LenOne || rsp_byte_length == LenTwo || rsp_byte_length == LenThree || rsp_byte_length == LenFour)

   // single bytes only ever carry ascii
   `USD_ASSERT_SAME(a_ascii_only, clock, reset, rsp_valid && rsp_byte_length == LenOne, rsp_code_point[CpWidth-1:7] == '0 && rsp_code_point != '0 && rsp_code_point != 21'h0A)

   // a held transfer keeps its payload
   `USD_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_code_point) && $stable(rsp_byte_length) && $stable(rsp_string_end))

endmodule

bind utf8_stream_decoder_core usd_checker u_usd_checker (.*);
